/* rtl/tuning_command_frame_parser_assert.svh */
// Assertion macros used by the tuning command frame parser RTL.
`ifndef TUNING_COMMAND_FRAME_PARSER_ASSERT_SVH
`define TUNING_COMMAND_FRAME_PARSER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCFP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tcfp_pkg.sv */
// Types and constants of the tuning command frame parser.
package tcfp_pkg;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_MODE   = 3'd1,
		PH_PARAM  = 3'd2,
		PH_SELECT = 3'd3,
		PH_SWITCH = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_PARAM     = 3'd1,
		ST_WRITTEN   = 3'd2,
		ST_ON        = 3'd3,
		ST_OFF       = 3'd4,
		ST_REJECT    = 3'd5,
		ST_BAD_INDEX = 3'd6
	} status_t;

	localparam logic [7:0] HEADER_BYTE = 8'hF0;
	localparam logic [7:0] MODE_PARAM  = 8'h00;
	localparam logic [7:0] MODE_SELECT = 8'h01;
	localparam logic [7:0] MODE_SWITCH = 8'h02;
	localparam logic [7:0] SW_ON_BYTE  = 8'h0A;
	localparam logic [7:0] SW_OFF_BYTE = 8'hB0;

	localparam logic [2:0] LAST_PAYLOAD = 3'd4;

	localparam logic [7:0] EXP_BIAS     = 8'd127;
	localparam logic [7:0] EXP_TOO_BIG  = 8'd135;
	localparam logic [7:0] EXP_SPECIAL  = 8'hFF;
	localparam logic [7:0] VALUE_MAX    = 8'hFF;

	typedef struct packed {
		logic [7:0] value;
		logic       clipped;
	} conv_t;

endpackage

/* rtl/tuning_command_frame_parser.sv */
// Top level of the tuning command frame parser.
// The parser takes one received byte per item and returns exactly one result item per byte:
// a status code, the channel table write caused by the byte (if any) and the enable flag.
// A frame is header 0xF0, a mode byte and five payload bytes; select frames carry the
// channel index and a big-endian single that is truncated and saturated to 0..255.
// Throughput is one byte per clock cycle while the output is not stalled. An accepted byte
// is held in the input register for one pass of parser logic, and the result register
// captures the outcome when the output can advance. While a result waits at the
// output, the input register takes one more byte and then the input stalls.
module tuning_command_frame_parser
	import tcfp_pkg::*;
#(
	parameter int NUM_CHANNELS = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // chunk_end, not used by the parser
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] frame_status, [3] write_valid, [7:4] write_index, [15:8] write_value,
	// [16] value_clipped, [17] enable_flag, [23:18] zero
	output logic [23:0] m_tdata
);

	localparam logic [8:0] NUM_CH = 9'(NUM_CHANNELS);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       fire;

	phase_t     phase_q, phase_d;
	logic [2:0] count_q, count_d;
	logic [2:0] count_inc;
	logic       done;
	logic [7:0] buf_q [4];
	logic       enable_q, enable_d;

	status_t    status_d;
	logic       wvalid_d;
	logic [3:0] widx_d;
	logic [7:0] wval_d;
	logic       clip_d;
	logic       all_on;
	logic       all_off;
	conv_t      conv;

	logic       m_tvalid_q;
	status_t    status_q;
	logic       wvalid_q;
	logic [3:0] widx_q;
	logic [7:0] wval_q;
	logic       clip_q;
	logic       flag_q;

	assign advance  = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	tcfp_f2u8 u_conv (
		.bits   ({buf_q[1], buf_q[2], buf_q[3], byte_s1}),
		.result (conv)
	);

	assign count_inc = 3'(count_q + 3'd1);
	assign done      = (count_inc > LAST_PAYLOAD) || (count_inc == 3'd0);
	assign all_on    = (buf_q[0] == SW_ON_BYTE) && (buf_q[1] == SW_ON_BYTE) &&
		(buf_q[2] == SW_ON_BYTE) && (buf_q[3] == SW_ON_BYTE) && (byte_s1 == SW_ON_BYTE);
	assign all_off   = (buf_q[0] == SW_OFF_BYTE) && (buf_q[1] == SW_OFF_BYTE) &&
		(buf_q[2] == SW_OFF_BYTE) && (buf_q[3] == SW_OFF_BYTE) && (byte_s1 == SW_OFF_BYTE);

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		enable_d = enable_q;
		status_d = ST_NONE;
		wvalid_d = 1'b0;
		widx_d   = 4'd0;
		wval_d   = 8'd0;
		clip_d   = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (byte_s1 == HEADER_BYTE) begin
					phase_d = PH_MODE;
				end
			end
			PH_MODE: begin
				if (byte_s1 == MODE_PARAM) begin
					phase_d = PH_PARAM;
					count_d = 3'd0;
				end else if (byte_s1 == MODE_SELECT) begin
					phase_d = PH_SELECT;
					count_d = 3'd0;
				end else if (byte_s1 == MODE_SWITCH) begin
					phase_d = PH_SWITCH;
					count_d = 3'd0;
				end
			end
			PH_PARAM, PH_SELECT, PH_SWITCH: begin
				count_d = count_inc;
				if (done) begin
					phase_d = PH_HEADER;
					unique case (phase_q)
						PH_PARAM: begin
							status_d = ST_PARAM;
						end
						PH_SELECT: begin
							if ({1'b0, buf_q[0]} < NUM_CH) begin
								status_d = ST_WRITTEN;
								wvalid_d = 1'b1;
								widx_d   = buf_q[0][3:0];
								wval_d   = conv.value;
								clip_d   = conv.clipped;
							end else begin
								status_d = ST_BAD_INDEX;
							end
						end
						default: begin
							priority if (all_on) begin
								enable_d = 1'b1;
								status_d = ST_ON;
							end else if (all_off) begin
								enable_d = 1'b0;
								status_d = ST_OFF;
							end else begin
								status_d = ST_REJECT;
							end
						end
					endcase
				end
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			count_q  <= 3'd0;
			enable_q <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			enable_q <= enable_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (phase_q == PH_PARAM || phase_q == PH_SELECT || phase_q == PH_SWITCH) &&
			!count_q[2]) begin
			buf_q[count_q[1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
			wvalid_q <= wvalid_d;
			widx_q   <= widx_d;
			wval_q   <= wval_d;
			clip_q   <= clip_d;
			flag_q   <= enable_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, flag_q, clip_q, wval_q, widx_q, wvalid_q, status_q};

`include "tuning_command_frame_parser_assert.svh"

	`TCFP_ASSERT_SAME(a_write_status, clk, arst_n, m_tvalid_q,
		wvalid_q == (status_q == ST_WRITTEN), "write_valid disagrees with frame status")
	`TCFP_ASSERT_SAME(a_write_index, clk, arst_n, m_tvalid_q && wvalid_q,
		{5'd0, widx_q} < NUM_CH, "channel write index out of range")
	`TCFP_ASSERT_SAME(a_clip_only_on_write, clk, arst_n, m_tvalid_q && clip_q,
		wvalid_q, "clip reported without a channel write")
	`TCFP_ASSERT_SAME(a_flag_matches_switch, clk, arst_n,
		m_tvalid_q && (status_q == ST_ON || status_q == ST_OFF),
		flag_q == (status_q == ST_ON), "enable flag does not follow switch frame")
	`TCFP_ASSERT_NEXT(a_frame_end, clk, arst_n,
		fire && (phase_q == PH_PARAM || phase_q == PH_SELECT || phase_q == PH_SWITCH) && done,
		phase_q == PH_HEADER, "parser did not return to header after a frame")

endmodule

/* rtl/tcfp_f2u8.sv */
// Converts a single-precision float to an unsigned byte, truncating and saturating.
module tcfp_f2u8
	import tcfp_pkg::*;
(
	input  logic [31:0] bits,
	output conv_t       result
);

	logic       neg;
	logic [7:0] ex;
	logic [2:0] k;
	logic [7:0] mant_top;

	assign neg      = bits[31];
	assign ex       = bits[30:23];
	assign k        = 3'(ex - EXP_BIAS);
	assign mant_top = {1'b1, bits[22:16]};

	always_comb begin
		result = '0;
		priority if (ex == EXP_SPECIAL) begin
			result.clipped = 1'b1;
			result.value   = ((|bits[22:0]) || neg) ? 8'd0 : VALUE_MAX;
		end else if (ex < EXP_BIAS) begin
			result.clipped = 1'b0;
			result.value   = 8'd0;
		end else if (ex >= EXP_TOO_BIG) begin
			result.clipped = 1'b1;
			result.value   = neg ? 8'd0 : VALUE_MAX;
		end else if (neg) begin
			result.clipped = 1'b1;
			result.value   = 8'd0;
		end else begin
			result.clipped = 1'b0;
			result.value   = mant_top >> (3'd7 - k);
		end
	end

endmodule
